/* hdl/orb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_pkg
// Shared types and constants for the overwriting ring buffer with max.
// ----------------------------------------------------------------------------
package orb_pkg;

  localparam int unsigned ValW  = 32;
  localparam int unsigned RankW = 9;
  localparam int unsigned CntW  = 9;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_LARGEST = 2'd3
  } cmd_e;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [CntW-1:0]        count;
    logic                   status;
  } res_t;

endpackage

/* hdl/orb_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_mem
// Sample store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module orb_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [orb_pkg::ValW-1:0]     wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [orb_pkg::ValW-1:0]     rdata_o
);
  import orb_pkg::*;

  logic [ValW-1:0] mem_q [DEPTH];
  logic [ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/orb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orb_ctrl
// Command sequencer: ring pointers, store access and the largest-value walk.
// ----------------------------------------------------------------------------
module orb_ctrl #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned CW    = 9
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic signed [orb_pkg::ValW-1:0] sample_i,
  input  logic [orb_pkg::RankW-1:0]     rank_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output orb_pkg::res_t                 res_o,
  output logic                          mem_we_o,
  output logic [AW-1:0]                 mem_waddr_o,
  output logic [orb_pkg::ValW-1:0]      mem_wdata_o,
  output logic                          mem_re_o,
  output logic [AW-1:0]                 mem_raddr_o,
  input  logic [orb_pkg::ValW-1:0]      mem_rdata_i
);
  import orb_pkg::*;

  localparam int unsigned RW = (CW > RankW) ? CW : RankW;
  localparam logic [AW:0] DepthW = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [AW-1:0]          oldest_q;
  logic [CW-1:0]          count_q;
  logic                   full_q;
  logic [AW-1:0]          ptr_q;
  logic [CW-1:0]          left_q;
  logic signed [ValW-1:0] best_q;
  res_t                   res_q;

  cmd_e          cmd;
  logic          acc;
  logic [AW:0]   push_sum;
  logic [AW:0]   rd_sum;
  logic [RW-1:0] rank_ext;
  logic [RW-1:0] cnt_ext;
  logic          rank_bad;
  logic signed [ValW-1:0] rd_val;
  logic signed [ValW-1:0] best_nx;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    if (s >= DepthW) begin
      wrap = AW'(s - DepthW);
    end else begin
      wrap = s[AW-1:0];
    end
  endfunction

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    if (p == LastIdx) begin
      inc = '0;
    end else begin
      inc = p + AW'(1);
    end
  endfunction

  assign cmd        = cmd_e'(cmd_i);
  assign in_ready_o = (state_q == ST_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  assign push_sum = {1'b0, oldest_q} + (AW+1)'(count_q);
  assign rank_ext = RW'(rank_i);
  assign cnt_ext  = RW'(count_q);
  assign rank_bad = (rank_i == '0) || (rank_ext > cnt_ext);
  assign rd_sum   = {1'b0, oldest_q} + (AW+1)'(rank_ext - RW'(1));

  assign rd_val  = $signed(mem_rdata_i);
  assign best_nx = (rd_val > best_q) ? rd_val : best_q;

  assign mem_we_o    = acc && (cmd == CMD_PUSH);
  assign mem_waddr_o = full_q ? oldest_q : wrap(push_sum);
  assign mem_wdata_o = sample_i;

  always_comb begin
    if (state_q == ST_SCAN) begin
      mem_raddr_o = ptr_q;
      mem_re_o    = (left_q > CW'(1));
    end else begin
      mem_raddr_o = (cmd == CMD_READ) ? wrap(rd_sum) : oldest_q;
      mem_re_o    = acc && (((cmd == CMD_READ) && !rank_bad) ||
                            ((cmd == CMD_LARGEST) && (count_q != '0)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      oldest_q <= '0;
      count_q  <= '0;
      full_q   <= 1'b0;
      ptr_q    <= '0;
      left_q   <= '0;
      best_q   <= '0;
      res_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            res_q.value  <= '0;
            res_q.status <= (cmd == CMD_READ) && rank_bad;
            unique case (cmd)
              CMD_PUSH: begin
                if (full_q) begin
                  oldest_q    <= inc(oldest_q);
                  res_q.count <= CntW'(count_q);
                end else begin
                  count_q     <= count_q + CW'(1);
                  full_q      <= ((count_q + CW'(1)) == DepthC);
                  res_q.count <= CntW'(count_q + CW'(1));
                end
                state_q <= ST_DONE;
              end
              CMD_READ: begin
                res_q.count <= CntW'(count_q);
                state_q     <= rank_bad ? ST_DONE : ST_RD;
              end
              CMD_CLEAR: begin
                oldest_q    <= '0;
                count_q     <= '0;
                full_q      <= 1'b0;
                res_q.count <= '0;
                state_q     <= ST_DONE;
              end
              CMD_LARGEST: begin
                res_q.count <= CntW'(count_q);
                best_q      <= '0;
                ptr_q       <= inc(oldest_q);
                left_q      <= count_q;
                state_q     <= (count_q == '0) ? ST_DONE : ST_SCAN;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_RD: begin
          res_q.value <= rd_val;
          state_q     <= ST_DONE;
        end
        ST_SCAN: begin
          best_q <= best_nx;
          if (left_q > CW'(1)) begin
            ptr_q  <= inc(ptr_q);
            left_q <= left_q - CW'(1);
          end else begin
            res_q.value <= best_nx;
            state_q     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

/* hdl/overwriting_ring_buffer_with_max.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_with_max
// Fixed-depth history of signed Q16.16 samples with read-by-rank and max.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_ready_o) carries cmd_i, sample_i, rank_i.
// Output channel (out_valid_o / out_ready_i) carries value_o, count_o,
// status_o, one result item per input item, in order.
// One item is in work at a time; the sequencer steps through a synchronous
// sample store (one write port, one read port) with registered read data.
//   push, clear, read out of range: no store read
//   read in range:                  one store read
//   largest:                        one store read per held sample, one a cycle
// An output register holds the finished result, so a stalled receiver only
// blocks once a second result is ready to leave the sequencer.
// Reset empties the buffer (count, pointers and full flag to zero) at once;
// store contents are not cleared.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_with_max #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      cmd_i,
  input  logic signed [orb_pkg::ValW-1:0] sample_i,
  input  logic [orb_pkg::RankW-1:0]       rank_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [orb_pkg::ValW-1:0] value_o,
  output logic [orb_pkg::CntW-1:0]        count_o,
  output logic                            status_o
);
  import orb_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic            res_valid;
  logic            res_ready;
  res_t            res;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [ValW-1:0] mem_wdata;
  logic            mem_re;
  logic [AW-1:0]   mem_raddr;
  logic [ValW-1:0] mem_rdata;
  logic            out_valid_q;
  res_t            out_q;

  orb_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .sample_i    (sample_i),
    .rank_i      (rank_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  orb_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_q.value;
  assign count_o     = out_q.count;
  assign status_o    = out_q.status;

  // sequencer never takes an item while holding a result
  a_ready_vs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && res_valid))
    else $error("input ready while result pending");

  // a handed-over result lands in the output register
  a_handover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res_ready) |=> out_valid_q)
    else $error("result lost at handover");

  // an error status carries a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status) |-> (res.value == '0))
    else $error("error result with non-zero value");

endmodule

/* tb/history_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// history_checker
// Watches both channels of the sample history. Each accepted item is run
// through a shadow copy of the ring to form its result, which waits in order
// until the block hands one over; value, count and status are then compared.
// ----------------------------------------------------------------------------
module history_checker #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic [1:0]                      cmd_i,
  input  logic signed [orb_pkg::ValW-1:0] sample_i,
  input  logic [orb_pkg::RankW-1:0]       rank_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic signed [orb_pkg::ValW-1:0] value_i,
  input  logic [orb_pkg::CntW-1:0]        count_i,
  input  logic                            status_i,
  output int                              fail_count_o,
  output int                              due_count_o,
  output int                              result_count_o
);
  import orb_pkg::*;

  logic [ValW-1:0] ring_q [DEPTH];
  int unsigned     oldest_pos;
  int unsigned     held_num;
  bit              ring_full;
  res_t            due_res_q [$];
  int              fail_tally;
  int              result_tally;

  function automatic res_t apply_cmd(cmd_e op, logic [ValW-1:0] smp,
                                     logic [RankW-1:0] rk);
    res_t        r;
    int signed   best;
    int unsigned pos;
    r = '0;
    case (op)
      CMD_PUSH: begin
        if (ring_full) begin
          ring_q[oldest_pos] = smp;
          oldest_pos = (oldest_pos + 1) % DEPTH;
        end else begin
          ring_q[(oldest_pos + held_num) % DEPTH] = smp;
          held_num++;
          if (held_num >= DEPTH) ring_full = 1'b1;
        end
      end
      CMD_READ: begin
        if (rk == 0 || rk > held_num) r.status = 1'b1;
        else r.value = ring_q[(oldest_pos + rk - 1) % DEPTH];
      end
      CMD_CLEAR: begin
        oldest_pos = 0;
        held_num   = 0;
        ring_full  = 1'b0;
      end
      default: begin
        // maximum starts from zero, so negatives alone give zero
        best = 0;
        pos  = oldest_pos;
        for (int i = 0; i < held_num; i++) begin
          if ($signed(ring_q[pos]) > best) best = $signed(ring_q[pos]);
          pos = (pos + 1) % DEPTH;
        end
        r.value = best;
      end
    endcase
    r.count = held_num[CntW-1:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      oldest_pos = 0;
      held_num   = 0;
      ring_full  = 1'b0;
      due_res_q.delete();
      fail_tally   = 0;
      result_tally = 0;
      fail_count_o   <= 0;
      due_count_o    <= 0;
      result_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        result_tally++;
        if (due_res_q.size() == 0) begin
          $error("result with no item awaiting it: value %0d count %0d status %0d",
                 value_i, count_i, status_i);
          fail_tally++;
        end else begin
          want = due_res_q.pop_front();
          if (value_i !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value_i);
            fail_tally++;
          end
          if (count_i !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count_i);
            fail_tally++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fail_tally++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_res_q.push_back(apply_cmd(cmd_e'(cmd_i), sample_i, rank_i));
      end
      fail_count_o   <= fail_tally;
      due_count_o    <= due_res_q.size();
      result_count_o <= result_tally;
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the overwriting sample history: a directed opening
// on empty, extreme and all-negative contents, then random push-heavy traffic
// that fills and overwrites the ring, then mixed traffic with clears. Both
// channels idle at random; one long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import orb_pkg::*;

  localparam int unsigned DEPTH       = 256;
  localparam int          STALL_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_WAIT  = 300;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             cmd_i;
  logic signed [ValW-1:0] sample_i;
  logic [RankW-1:0]       rank_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [ValW-1:0] value_o;
  logic [CntW-1:0]        count_o;
  logic                   status_o;

  int fail_count;
  int due_count;
  int result_count;
  int fill_est;
  int sent_by_cmd [4];
  int quiet_cycles;
  bit calm;
  bit hold_req;

  overwriting_ring_buffer_with_max #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .sample_i   (sample_i),
    .rank_i     (rank_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o),
    .count_o    (count_o),
    .status_o   (status_o)
  );

  history_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .cmd_i         (cmd_i),
    .sample_i      (sample_i),
    .rank_i        (rank_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_i       (value_o),
    .count_i       (count_o),
    .status_i      (status_o),
    .fail_count_o  (fail_count),
    .due_count_o   (due_count),
    .result_count_o(result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("overwriting_ring_buffer_with_max: mismatch");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, one long hold-off on request
  initial begin
    bit hold_done;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  task automatic send_item(input cmd_e op, input logic [ValW-1:0] smp,
                           input logic [RankW-1:0] rk);
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= op;
    sample_i   <= smp;
    rank_i     <= rk;
    do @(posedge clk_i); while (!in_ready_o);
    sent_by_cmd[op]++;
    case (op)
      CMD_PUSH:  if (fill_est < DEPTH) fill_est++;
      CMD_CLEAR: fill_est = 0;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (due_count != 0);
  endtask

  function automatic logic [ValW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return -$urandom_range(1, 32'h0010_0000);
      3:       return $urandom_range(0, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [RankW-1:0] pick_rank();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return RankW'(fill_est + 1);
      2:       return RankW'($urandom_range(0, 511));
      default: return (fill_est == 0) ? 9'd1 : RankW'($urandom_range(1, fill_est));
    endcase
  endfunction

  task automatic mix_items(input int n, input int push_pct, input int read_pct,
                           input int largest_pct);
    int   r;
    cmd_e op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) op = CMD_PUSH;
      else if (r < push_pct + read_pct) op = CMD_READ;
      else if (r < push_pct + read_pct + largest_pct) op = CMD_LARGEST;
      else op = CMD_CLEAR;
      send_item(op, (op == CMD_PUSH) ? pick_sample() : $urandom,
                (op == CMD_READ) ? pick_rank() : RankW'($urandom_range(0, 511)));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_i        = CMD_PUSH;
    sample_i     = '0;
    rank_i       = '0;
    fill_est     = 0;
    quiet_cycles = 0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    foreach (sent_by_cmd[i]) sent_by_cmd[i] = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty ring
    send_item(CMD_READ, $urandom, 9'd1);
    send_item(CMD_LARGEST, $urandom, RankW'($urandom_range(0, 511)));
    // extremes
    send_item(CMD_PUSH, 32'h7fff_ffff, RankW'($urandom_range(0, 511)));
    send_item(CMD_PUSH, 32'h8000_0000, RankW'($urandom_range(0, 511)));
    send_item(CMD_PUSH, 32'h0000_0000, RankW'($urandom_range(0, 511)));
    send_item(CMD_PUSH, 32'hffff_ffff, RankW'($urandom_range(0, 511)));
    send_item(CMD_READ, $urandom, 9'd0);
    send_item(CMD_READ, $urandom, 9'd1);
    send_item(CMD_READ, $urandom, 9'd2);
    send_item(CMD_READ, $urandom, 9'd4);
    send_item(CMD_READ, $urandom, 9'd5);
    send_item(CMD_READ, $urandom, 9'd256);
    send_item(CMD_READ, $urandom, 9'd511);
    send_item(CMD_LARGEST, $urandom, RankW'($urandom_range(0, 511)));
    send_item(CMD_CLEAR, $urandom, RankW'($urandom_range(0, 511)));
    send_item(CMD_READ, $urandom, 9'd1);
    // all negative
    send_item(CMD_PUSH, 32'hfffb_0000, RankW'($urandom_range(0, 511)));
    send_item(CMD_PUSH, 32'h8000_0000, RankW'($urandom_range(0, 511)));
    send_item(CMD_PUSH, 32'hffff_ffff, RankW'($urandom_range(0, 511)));
    send_item(CMD_LARGEST, $urandom, RankW'($urandom_range(0, 511)));
    send_item(CMD_READ, $urandom, 9'd3);
    send_item(CMD_CLEAR, $urandom, RankW'($urandom_range(0, 511)));
    send_item(CMD_LARGEST, $urandom, RankW'($urandom_range(0, 511)));

    // sender pause until the block has drained
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();

    // fill and overwrite
    mix_items(120, 75, 14, 11);
    calm = 1'b1;
    mix_items(80, 75, 14, 11);
    calm     = 1'b0;
    hold_req = 1'b1;
    mix_items(200, 75, 14, 11);
    // mixed with clears
    mix_items(150, 35, 30, 20);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d items: %0d push, %0d read, %0d clear, %0d largest; %0d results checked.",
             sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3],
             sent_by_cmd[0], sent_by_cmd[1], sent_by_cmd[2], sent_by_cmd[3], result_count);
    $display("Covered empty and full ring, overwrite of oldest, bad ranks and a long stall.");
    if (fail_count == 0 && due_count == 0) begin
      $display("overwriting_ring_buffer_with_max: match");
    end else begin
      $display("overwriting_ring_buffer_with_max: mismatch");
    end
    $finish;
  end

endmodule
